>>> hdl/twq_pkg.sv
// ----------------------------------------------------------------------------
// twq_pkg
// Shared types and codes for the two-class weighted queue.
// ----------------------------------------------------------------------------
package twq_pkg;

    // Command codes of the input channel
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SERVE  = 2'd2;

    // Status codes of the result channel
    localparam logic [1:0] STS_DONE = 2'd0;
    localparam logic [1:0] STS_NONE = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    // Entry classes
    localparam logic CLS_NORMAL = 1'b0;
    localparam logic CLS_PREF   = 1'b1;

    // Configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned BURST_W    = 4;
    localparam logic [0:0]  REG_PREF_BURST = 1'b0;
    localparam logic [BURST_W-1:0] PREF_BURST_RESET = 4'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

>>> hdl/two_class_weighted_queue.sv
// ----------------------------------------------------------------------------
// two_class_weighted_queue
// Arrival-ordered queue of normal and preferential entries with add,
// remove-oldest and weighted serve commands, kept in two entry memories.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  command  | in        | i_in_valid / o_in_stall   | cmd, entry_id, entry_class
//  result   | out       | o_out_valid / i_out_stall | status, removed_id/class,
//           |           |                           | normal/pref/total counts
//  config   | in        | APB psel/penable/pready   | pref_burst at byte address 0
//
//  For each command, the transfer cycle issues the read of both head
//  entries from the class memories, the next cycle sees the read data,
//  decides, writes back pointers, counts and (for add) the new entry, and loads
//  the result register. A new command is taken once that result register is
//  free or being drained. The memories need no clearing: an entry is read only
//  after it was written. Reset is synchronous, active low; a stalled result
//  holds its register and stalls the command side.
//
module two_class_weighted_queue
    import twq_pkg::*;
#(
    parameter int unsigned CAPACITY = 32,
    parameter int unsigned ID_WIDTH = 16,
    localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_cmd,
    input  logic [ID_WIDTH-1:0]   i_entry_id,
    input  logic                  i_entry_class,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [ID_WIDTH-1:0]   o_removed_id,
    output logic                  o_removed_class,
    output logic [CNT_W-1:0]      o_normal_count,
    output logic [CNT_W-1:0]      o_pref_count,
    output logic [CNT_W-1:0]      o_total_count,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned PTR_W  = $clog2(CAPACITY);
    // Stamps count modulo twice the capacity
    localparam int unsigned SW     = $clog2(2 * CAPACITY);
    localparam int unsigned ENT_W  = SW + ID_WIDTH;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(CAPACITY - 1);
    localparam logic [SW-1:0]    STAMP_LAST = SW'(2 * CAPACITY - 1);
    localparam logic [SW:0]      STAMP_MOD  = (SW + 1)'(2 * CAPACITY);
    localparam logic [CNT_W:0]   CAP_CNT    = (CNT_W + 1)'(CAPACITY);

    // ------------------------------------------------------------------
    // Entry memories: {stamp, id}, one per class, registered read
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] pref_mem [CAPACITY];
    logic [ENT_W-1:0] norm_mem [CAPACITY];
    logic [ENT_W-1:0] r_pref_rd, r_norm_rd;

    // ------------------------------------------------------------------
    // Control and pointer state
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [PTR_W-1:0]     r_pref_head, n_pref_head, r_pref_tail, n_pref_tail;
    logic [PTR_W-1:0]     r_norm_head, n_norm_head, r_norm_tail, n_norm_tail;
    logic [CNT_W-1:0]     r_pref_cnt, n_pref_cnt, r_norm_cnt, n_norm_cnt;
    logic [SW-1:0]        r_stamp, n_stamp;
    logic [BURST_W-1:0]   r_burst_cnt, n_burst_cnt;
    logic [BURST_W-1:0]   r_pref_burst;

    // Latched command
    logic [1:0]           r_cmd;
    logic [ID_WIDTH-1:0]  r_id;
    logic                 r_cls;

    // Result register
    logic                 r_out_valid;
    logic [1:0]           r_status, n_status;
    logic [ID_WIDTH-1:0]  r_rid, n_rid;
    logic                 r_rcls, n_rcls;
    logic [CNT_W-1:0]     r_out_norm, r_out_pref, r_out_total;

    logic                 w_in_xfer;
    logic                 w_exec;
    logic                 w_pref_we, w_norm_we;
    logic [ENT_W-1:0]     w_wr_entry;
    logic [CNT_W:0]       w_total;
    logic [SW:0]          w_age_p, w_age_n;
    logic                 w_take_pref;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign w_in_xfer = i_in_valid & ~o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_xfer) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Stall commands while one is in flight or the result cannot drain
    always_comb begin
        w_exec     = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: o_in_stall = r_out_valid & i_out_stall;
            ST_EXEC: w_exec = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Decide and update: read data of both heads is valid in ST_EXEC
    // ------------------------------------------------------------------
    assign w_total    = {1'b0, r_norm_cnt} + {1'b0, r_pref_cnt};
    assign w_wr_entry = {r_stamp, r_id};

    // Distance back from the next stamp, modulo twice the capacity
    always_comb begin
        w_age_p = {1'b0, r_stamp} - {1'b0, r_pref_rd[ENT_W-1:ID_WIDTH]};
        if (r_stamp < r_pref_rd[ENT_W-1:ID_WIDTH]) w_age_p = w_age_p + STAMP_MOD;
        w_age_n = {1'b0, r_stamp} - {1'b0, r_norm_rd[ENT_W-1:ID_WIDTH]};
        if (r_stamp < r_norm_rd[ENT_W-1:ID_WIDTH]) w_age_n = w_age_n + STAMP_MOD;
    end

    assign w_take_pref = (r_pref_cnt != '0) && ((r_norm_cnt == '0) || (w_age_p > w_age_n));

    always_comb begin
        n_pref_head = r_pref_head;
        n_pref_tail = r_pref_tail;
        n_norm_head = r_norm_head;
        n_norm_tail = r_norm_tail;
        n_pref_cnt  = r_pref_cnt;
        n_norm_cnt  = r_norm_cnt;
        n_stamp     = r_stamp;
        n_burst_cnt = r_burst_cnt;
        n_status    = STS_NONE;
        n_rid       = '0;
        n_rcls      = CLS_NORMAL;
        w_pref_we   = 1'b0;
        w_norm_we   = 1'b0;
        if (w_exec) begin
            case (r_cmd)
                CMD_ADD: begin
                    if (w_total >= CAP_CNT) begin
                        n_status = STS_FULL;
                    end else begin
                        if (r_cls == CLS_PREF) begin
                            w_pref_we   = 1'b1;
                            n_pref_tail = (r_pref_tail == PTR_LAST) ? '0 : r_pref_tail + 1'b1;
                            n_pref_cnt  = r_pref_cnt + 1'b1;
                        end else begin
                            w_norm_we   = 1'b1;
                            n_norm_tail = (r_norm_tail == PTR_LAST) ? '0 : r_norm_tail + 1'b1;
                            n_norm_cnt  = r_norm_cnt + 1'b1;
                        end
                        n_stamp  = (r_stamp == STAMP_LAST) ? '0 : r_stamp + 1'b1;
                        n_status = STS_DONE;
                    end
                end
                CMD_REMOVE: begin
                    if (w_total != '0) begin
                        n_status = STS_DONE;
                        if (w_take_pref) begin
                            n_pref_head = (r_pref_head == PTR_LAST) ? '0 : r_pref_head + 1'b1;
                            n_pref_cnt  = r_pref_cnt - 1'b1;
                            n_rid       = r_pref_rd[ID_WIDTH-1:0];
                            n_rcls      = CLS_PREF;
                        end else begin
                            n_norm_head = (r_norm_head == PTR_LAST) ? '0 : r_norm_head + 1'b1;
                            n_norm_cnt  = r_norm_cnt - 1'b1;
                            n_rid       = r_norm_rd[ID_WIDTH-1:0];
                        end
                    end
                end
                CMD_SERVE: begin
                    if (r_burst_cnt < r_pref_burst) begin
                        if (r_pref_cnt != '0) begin
                            n_pref_head = (r_pref_head == PTR_LAST) ? '0 : r_pref_head + 1'b1;
                            n_pref_cnt  = r_pref_cnt - 1'b1;
                            n_rid       = r_pref_rd[ID_WIDTH-1:0];
                            n_rcls      = CLS_PREF;
                            n_status    = STS_DONE;
                        end
                        n_burst_cnt = r_burst_cnt + 1'b1;
                    end else begin
                        if (r_norm_cnt != '0) begin
                            n_norm_head = (r_norm_head == PTR_LAST) ? '0 : r_norm_head + 1'b1;
                            n_norm_cnt  = r_norm_cnt - 1'b1;
                            n_rid       = r_norm_rd[ID_WIDTH-1:0];
                            n_status    = STS_DONE;
                        end
                        n_burst_cnt = '0;
                    end
                end
                default: n_status = STS_NONE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Memories: write the new entry at the tail, read both heads
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_pref_we) pref_mem[r_pref_tail] <= w_wr_entry;
        if (w_norm_we) norm_mem[r_norm_tail] <= w_wr_entry;
        r_pref_rd <= pref_mem[r_pref_head];
        r_norm_rd <= norm_mem[r_norm_head];
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pref_head  <= '0;
            r_pref_tail  <= '0;
            r_norm_head  <= '0;
            r_norm_tail  <= '0;
            r_pref_cnt   <= '0;
            r_norm_cnt   <= '0;
            r_stamp      <= '0;
            r_burst_cnt  <= '0;
            r_pref_burst <= PREF_BURST_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pref_head <= n_pref_head;
            r_pref_tail <= n_pref_tail;
            r_norm_head <= n_norm_head;
            r_norm_tail <= n_norm_tail;
            r_pref_cnt  <= n_pref_cnt;
            r_norm_cnt  <= n_norm_cnt;
            r_stamp     <= n_stamp;
            r_burst_cnt <= n_burst_cnt;
            // Configuration write on the access phase
            if (psel && penable && pwrite && pready && paddr[2] == REG_PREF_BURST) begin
                r_pref_burst <= pwdata[BURST_W-1:0];
            end
            // Load the result; drop it once transferred
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the command and the result payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd <= i_cmd;
            r_id  <= i_entry_id;
            r_cls <= i_entry_class;
        end
        if (w_exec) begin
            r_status    <= n_status;
            r_rid       <= n_rid;
            r_rcls      <= n_rcls;
            r_out_norm  <= n_norm_cnt;
            r_out_pref  <= n_pref_cnt;
            r_out_total <= n_norm_cnt + n_pref_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_id    = r_rid;
    assign o_removed_class = r_rcls;
    assign o_normal_count  = r_out_norm;
    assign o_pref_count    = r_out_pref;
    assign o_total_count   = r_out_total;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PREF_BURST) ?
                    {{(APB_DATA_W - BURST_W){1'b0}}, r_pref_burst} : '0;

endmodule

>>> tb/sv/twq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twq_scoreboard_pkg
// Predicts the outcome of each accepted command for the two-class weighted
// queue and checks every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
package twq_scoreboard_pkg;
    import twq_pkg::*;

    localparam int unsigned LINE_CAPACITY = 32;
    localparam int unsigned COUNT_W       = $clog2(LINE_CAPACITY + 1);
    localparam int unsigned REPORT_LIMIT  = 10;

    // Command value that the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        rid;
        logic               rcls;
        logic [COUNT_W-1:0] n_normal;
        logic [COUNT_W-1:0] n_pref;
        logic [COUNT_W-1:0] n_total;
    } outcome_t;

    typedef struct {
        logic [15:0] id;
        logic        cls;
    } waiting_entry_t;

    class twq_scoreboard;
        // Waiting line in arrival order, oldest at the front
        waiting_entry_t     line[$];
        int unsigned        normal_waiting;
        int unsigned        pref_waiting;
        logic [BURST_W-1:0] burst_count;
        logic [BURST_W-1:0] burst_limit;
        outcome_t           awaited[$];
        int unsigned        mismatches;

        function new();
            normal_waiting = 0;
            pref_waiting   = 0;
            burst_count    = '0;
            burst_limit    = PREF_BURST_RESET;
            mismatches     = 0;
        endfunction

        function void set_burst(logic [BURST_W-1:0] value);
            burst_limit = value;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function string describe(outcome_t o);
            return $sformatf("status=%0d id=%h cls=%0d normal=%0d pref=%0d total=%0d",
                             o.status, o.rid, o.rcls, o.n_normal, o.n_pref, o.n_total);
        endfunction

        function void log_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
        endfunction

        // Take the entry at position idx out of the line and report it
        function void take_entry(int idx, ref outcome_t o);
            o.rid    = line[idx].id;
            o.rcls   = line[idx].cls;
            o.status = STS_DONE;
            if (line[idx].cls == CLS_PREF) begin
                pref_waiting--;
            end else begin
                normal_waiting--;
            end
            line.delete(idx);
        endfunction

        // Work out the outcome of one accepted command and queue it
        function void note_command(logic [1:0] cmd, logic [15:0] id, logic cls);
            outcome_t       o;
            waiting_entry_t e;
            logic           wanted;
            int             idx;
            o        = '0;
            o.status = STS_NONE;
            idx      = -1;
            case (cmd)
                CMD_ADD: begin
                    if (line.size() >= LINE_CAPACITY) begin
                        o.status = STS_FULL;
                    end else begin
                        e.id  = id;
                        e.cls = cls;
                        line.push_back(e);
                        if (cls == CLS_PREF) begin
                            pref_waiting++;
                        end else begin
                            normal_waiting++;
                        end
                        o.status = STS_DONE;
                    end
                end
                CMD_REMOVE: begin
                    if (line.size() != 0) begin
                        take_entry(0, o);
                    end
                end
                CMD_SERVE: begin
                    // Preferential while the burst count is below the limit,
                    // otherwise one normal serve that restarts the burst
                    if (burst_count < burst_limit) begin
                        wanted      = CLS_PREF;
                        burst_count = burst_count + 1'b1;
                    end else begin
                        wanted      = CLS_NORMAL;
                        burst_count = '0;
                    end
                    for (int k = 0; k < line.size(); k++) begin
                        if (line[k].cls == wanted) begin
                            idx = k;
                            break;
                        end
                    end
                    if (idx >= 0) begin
                        take_entry(idx, o);
                    end
                end
                default: ;
            endcase
            o.n_normal = COUNT_W'(normal_waiting);
            o.n_pref   = COUNT_W'(pref_waiting);
            o.n_total  = COUNT_W'(normal_waiting + pref_waiting);
            awaited.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (awaited.size() == 0) begin
                log_mismatch({"result with no command outstanding: ", describe(got)});
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.rid !== want.rid ||
                got.rcls !== want.rcls || got.n_normal !== want.n_normal ||
                got.n_pref !== want.n_pref || got.n_total !== want.n_total) begin
                log_mismatch({"expected ", describe(want), " got ", describe(got)});
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-class weighted queue: a directed opening
// over empty, burst and class-order corners, then random command phases
// under different idle and stall patterns and burst settings, with every
// result transfer checked against a predicted outcome.
// ----------------------------------------------------------------------------
module tb_top;
    import twq_pkg::*;
    import twq_scoreboard_pkg::*;

    localparam int unsigned RUN_LIMIT    = 200000;
    localparam int unsigned PHASE_ITEMS  = 320;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SEGMENT      = 40;
    localparam logic [APB_ADDR_W-1:0] BURST_ADDR = APB_ADDR_W'(REG_PREF_BURST) << 2;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_cmd;
    logic [15:0]           i_entry_id;
    logic                  i_entry_class;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_status;
    logic [15:0]           o_removed_id;
    logic                  o_removed_class;
    logic [COUNT_W-1:0]    o_normal_count;
    logic [COUNT_W-1:0]    o_pref_count;
    logic [COUNT_W-1:0]    o_total_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Idle and stall chances in percent; hold_request asks the receiver for
    // one long stall. All three change only at a rising edge.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_request  = 0;
    int unsigned cycle_count   = 0;

    twq_scoreboard sb = new();

    two_class_weighted_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_entry_id      (i_entry_id),
        .i_entry_class   (i_entry_class),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_id    (o_removed_id),
        .o_removed_class (o_removed_class),
        .o_normal_count  (o_normal_count),
        .o_pref_count    (o_pref_count),
        .o_total_count   (o_total_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run; the limit is many times the slowest correct run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: stall at random, or hold off for a whole requested
    // stretch, counted here so the sender keeps offering meanwhile
    initial begin
        int unsigned hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Check every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result('{o_status, o_removed_id, o_removed_class,
                              o_normal_count, o_pref_count, o_total_count});
        end
    end

    // Offer one command from a falling edge; optionally idle first. Return at
    // the falling edge after the transfer with valid still high, so the next
    // call either keeps it up or drops it with a single assignment.
    task automatic send_command(logic [1:0] cmd, logic [15:0] id, logic cls);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_entry_id    <= id;
        i_entry_class <= cls;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(cmd, id, cls);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has arrived, then
    // let the command pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Set the idle and stall chances, and hold the request up across exactly
    // one falling edge so the receiver sees it once
    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct,
                              int unsigned hold);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        hold_request  = hold;
        @(posedge i_clk);
        hold_request  = 0;
        @(negedge i_clk);
    endtask

    // Write the burst register, then read it back; the block must be idle
    task automatic program_burst(logic [BURST_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BURST_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_burst(value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(value)) begin
            sb.log_mismatch($sformatf("burst register read %h, written %h", prdata, value));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random commands in segments with a changing mix: add-heavy stretches
    // fill the line to the refusal point, remove/serve-heavy ones drain it.
    // With pause_midway the sender stops until every result is back.
    task automatic run_phase(int unsigned items, bit pause_midway);
        int unsigned add_pct;
        int unsigned pref_pct;
        int unsigned pick;
        logic [1:0]  cmd;
        add_pct  = 50;
        pref_pct = 50;
        for (int unsigned n = 0; n < items; n++) begin
            if (n % SEGMENT == 0) begin
                case ($urandom_range(2))
                    0: add_pct = 85;
                    1: add_pct = 55;
                    default: add_pct = 25;
                endcase
                pref_pct = 20 + 30 * $urandom_range(2);
            end
            if (pause_midway && n == items / 2) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
                while (sb.pending() != 0) @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 3) begin
                cmd = CMD_UNUSED;
            end else if (pick < 3 + add_pct) begin
                cmd = CMD_ADD;
            end else if ($urandom_range(99) < 40) begin
                cmd = CMD_REMOVE;
            end else begin
                cmd = CMD_SERVE;
            end
            send_command(cmd, 16'($urandom_range(16'hFFFF)),
                         logic'($urandom_range(99) < pref_pct));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_ADD;
        i_entry_id    = '0;
        i_entry_class = CLS_NORMAL;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty line at the reset burst setting: remove and serve find
        // nothing, the serve still advances the burst count
        send_command(CMD_REMOVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_UNUSED, 16'h0000, CLS_NORMAL);
        // Extreme identifiers in both classes, interleaved by arrival
        send_command(CMD_ADD, 16'h0000, CLS_NORMAL);
        send_command(CMD_ADD, 16'hFFFF, CLS_PREF);
        send_command(CMD_ADD, 16'h5555, CLS_NORMAL);
        send_command(CMD_ADD, 16'hAAAA, CLS_PREF);
        // Burst count at one: preferential serve, then the normal serve
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        // Remove takes the oldest regardless of class
        send_command(CMD_REMOVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_REMOVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_ADD, 16'h1234, CLS_PREF);
        send_command(CMD_ADD, 16'h00FF, CLS_NORMAL);

        // Widest burst: serves keep asking for preferential entries even
        // with none waiting and no fallback to the normal one
        program_burst(4'd15);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        // Lower the burst below the running count: next serve is normal
        program_burst(4'd1);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        // Burst of zero: every serve is a normal serve
        program_burst(4'd0);
        send_command(CMD_ADD, 16'h0F0F, CLS_PREF);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_SERVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_REMOVE, 16'h0000, CLS_NORMAL);
        send_command(CMD_UNUSED, 16'hFFFF, CLS_PREF);

        // Back-to-back transfers, no idling on either side
        program_burst(BURST_W'($urandom_range(1, 14)));
        set_idling(0, 0, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        program_burst(4'd15);
        set_idling(85, 0, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        program_burst(4'd1);
        set_idling(0, 85, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        program_burst(4'd0);
        set_idling(30, 30, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        // Long receiver hold while commands keep coming, so the block backs
        // up and stalls its input; the sender then waits for a full drain
        program_burst(BURST_W'($urandom_range(1, 15)));
        set_idling(0, 0, HOLD_CYCLES);
        run_phase(PHASE_ITEMS, 1'b1);

        program_burst(BURST_W'($urandom_range(15)));
        set_idling(30, 30, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        settle();
        repeat (10) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
